/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/i2crf_pkg.sv */
// ----------------------------------------------------------------------------
// i2crf_pkg
// types, codes and reset contents shared by the i2c target register file
// ----------------------------------------------------------------------------
package i2crf_pkg;

  localparam logic [2:0] OP_WR_ADDR  = 3'd0;
  localparam logic [2:0] OP_BYTE_RX  = 3'd1;
  localparam logic [2:0] OP_RD_ADDR  = 3'd2;
  localparam logic [2:0] OP_BYTE_TX  = 3'd3;
  localparam logic [2:0] OP_STOP     = 3'd4;
  localparam logic [2:0] OP_BUS_ERR  = 3'd5;
  localparam logic [2:0] OP_LOCAL_RD = 3'd6;
  localparam logic [2:0] OP_LOCAL_WR = 3'd7;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_PTR  = 3'd1;
  localparam logic [2:0] PH_RX   = 3'd2;
  localparam logic [2:0] PH_TX   = 3'd3;

  localparam logic [7:0] CMD_RESET = 8'h01;
  localparam logic [7:0] CMD_RELOAD = 8'h02;
  localparam logic [7:0] CMD_BOOT  = 8'h03;

  localparam logic [7:0] BYTE_EMPTY = 8'hFF;
  localparam logic [7:0] BYTE1_INIT = 8'hAA;
  localparam logic [7:0] BYTE2_INIT = 8'h10;
  localparam logic [7:0] BYTE3_INIT = 8'h01;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_in;
    logic [7:0] reg_index;
  } in_req_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       data_valid;
    logic       write_done;
    logic       read_done;
    logic       reset_request;
    logic       boot_request;
  } out_rsp_t;

  typedef struct packed {
    logic       rd_en;
    logic       wr_en;
    logic [7:0] addr;
    logic [7:0] wdata;
  } mem_req_t;

  typedef struct packed {
    out_rsp_t rsp;
    logic     use_mem;
  } rsp_info_t;

  function automatic logic [7:0] reset_byte(input logic [7:0] addr);
    logic [7:0] b;
    case (addr)
      8'd1:    b = BYTE1_INIT;
      8'd2:    b = BYTE2_INIT;
      8'd3:    b = BYTE3_INIT;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* rtl/i2crf_mem.sv */
// ----------------------------------------------------------------------------
// i2crf_mem
// register byte store, one port, registered read, per-entry written flags
// ----------------------------------------------------------------------------
module i2crf_mem import i2crf_pkg::*; #(
  parameter int REG_BYTES = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  mem_req_t   mem_req,
  output logic [7:0] rd_data
);

  localparam int AW = $clog2(REG_BYTES);

  logic [7:0]           mem [REG_BYTES];
  logic [REG_BYTES-1:0] vld_r;
  logic [7:0]           rd_q_r;
  logic [7:0]           rd_init_r;
  logic                 rd_vld_r;
  logic [AW-1:0]        addr;

  assign addr = mem_req.addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[addr] <= mem_req.wdata;
    end
    if (mem_req.rd_en) begin
      rd_q_r    <= mem[addr];
      rd_vld_r  <= vld_r[addr];
      rd_init_r <= reset_byte(mem_req.addr);
    end
  end

  // entries never written read back their reset contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_req.wr_en) begin
      vld_r[addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : rd_init_r;

endmodule

/* rtl/i2crf_ctrl.sv */
// ----------------------------------------------------------------------------
// i2crf_ctrl
// bus phase, register pointer and command byte; issues memory requests
// ----------------------------------------------------------------------------
module i2crf_ctrl import i2crf_pkg::*; #(
  parameter int REG_BYTES = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_req_t   req,
  output mem_req_t  mem_req,
  output rsp_info_t info
);

  localparam logic [8:0] DEPTH = 9'(REG_BYTES);

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] ptr_r, ptr_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic       ptr_in, idx_in;
  mem_req_t   mreq;

  assign ptr_in = {1'b0, ptr_r} < DEPTH;
  assign idx_in = {1'b0, req.reg_index} < DEPTH;

  always_comb begin
    phase_nxt = phase_r;
    ptr_nxt   = ptr_r;
    cmd_nxt   = cmd_r;
    mreq      = '0;
    info      = '0;
    case (req.operation)
      OP_WR_ADDR: begin
        phase_nxt = PH_PTR;
      end
      OP_BYTE_RX: begin
        if (phase_r == PH_PTR) begin
          ptr_nxt   = req.data_in;
          phase_nxt = PH_RX;
        end else if (phase_r == PH_RX && ptr_in) begin
          ptr_nxt = ptr_r + 8'd1;
          if (ptr_r == 8'd0) begin
            cmd_nxt = req.data_in;
          end else begin
            mreq.wr_en = 1'b1;
            mreq.addr  = ptr_r;
            mreq.wdata = req.data_in;
          end
        end
      end
      OP_RD_ADDR, OP_BYTE_TX: begin
        if (req.operation == OP_RD_ADDR) begin
          phase_nxt = PH_TX;
        end
        info.rsp.data_valid = 1'b1;
        if (ptr_in) begin
          ptr_nxt = ptr_r + 8'd1;
          if (ptr_r == 8'd0) begin
            info.rsp.data_out = cmd_r;
          end else begin
            mreq.rd_en   = 1'b1;
            mreq.addr    = ptr_r;
            info.use_mem = 1'b1;
          end
        end else begin
          info.rsp.data_out = BYTE_EMPTY;
        end
      end
      OP_STOP: begin
        if (phase_r == PH_RX) begin
          info.rsp.write_done = 1'b1;
          case (cmd_r)
            CMD_RESET: info.rsp.reset_request = 1'b1;
            CMD_RELOAD: begin
              mreq.wr_en = 1'b1;
              mreq.addr  = 8'd1;
              mreq.wdata = BYTE1_INIT;
            end
            CMD_BOOT:  info.rsp.boot_request = 1'b1;
            default:   ;
          endcase
          cmd_nxt = 8'h00;
        end else if (phase_r == PH_TX) begin
          info.rsp.read_done = 1'b1;
        end
        phase_nxt = PH_IDLE;
      end
      OP_BUS_ERR: begin
        phase_nxt = PH_IDLE;
      end
      OP_LOCAL_RD: begin
        info.rsp.data_valid = 1'b1;
        if (!idx_in) begin
          info.rsp.data_out = BYTE_EMPTY;
        end else if (req.reg_index == 8'd0) begin
          info.rsp.data_out = cmd_r;
        end else begin
          mreq.rd_en   = 1'b1;
          mreq.addr    = req.reg_index;
          info.use_mem = 1'b1;
        end
      end
      OP_LOCAL_WR: begin
        if (idx_in) begin
          if (req.reg_index == 8'd0) begin
            cmd_nxt = req.data_in;
          end else begin
            mreq.wr_en = 1'b1;
            mreq.addr  = req.reg_index;
            mreq.wdata = req.data_in;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_req       = mreq;
    mem_req.rd_en = mreq.rd_en & fire;
    mem_req.wr_en = mreq.wr_en & fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      ptr_r   <= 8'd0;
      cmd_r   <= 8'h00;
    end else if (fire) begin
      phase_r <= phase_nxt;
      ptr_r   <= ptr_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

endmodule

/* rtl/i2c_target_register_file.sv */
// ----------------------------------------------------------------------------
// i2c_target_register_file
// register map behind an i2c target with pointer auto-increment
// ----------------------------------------------------------------------------
// in_data carries one decoded bus event or local access per request on a
// valid/ready channel; out_data returns exactly one response per request.
// latency: the response is valid in the cycle after the request is taken.
// throughput: one request per cycle while out_ready is high; the single-port
// byte store sees at most one read or one write per request.
// byte 0 (command byte) lives in a flop, the other bytes in the store;
// a stop after a write runs the command and clears byte 0.
// reset: pointer 0, phase idle, bytes 1..3 read back 0xaa, 0x10, 0x01 and
// all others 0 until written; no request is taken while rst_n is low.
// stall: the response stays in the output register while out_ready is
// low and in_ready drops; a new request is taken in the same cycle that
// the pending response is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_target_register_file import i2crf_pkg::*; #(
  parameter int REG_BYTES = 128
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_data
);

  logic       in_fire;
  logic       out_valid_r;
  rsp_info_t  info;
  rsp_info_t  info_r;
  mem_req_t   mem_req;
  logic [7:0] rd_data;

  assign in_ready = rst_n & (~out_valid_r | out_ready);
  assign in_fire  = in_valid & in_ready;

  i2crf_ctrl #(
    .REG_BYTES (REG_BYTES)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (in_fire),
    .req     (in_data),
    .mem_req (mem_req),
    .info    (info)
  );

  i2crf_mem #(
    .REG_BYTES (REG_BYTES)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      info_r <= info;
    end
  end

  always_comb begin
    out_data = info_r.rsp;
    if (info_r.use_mem) begin
      out_data.data_out = rd_data;
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_PROP(a_rsp_follows_req, clk, rst_n, in_fire |=> out_valid, "request gave no response")
  `ASSERT_PROP(a_stall_blocks_in, clk, rst_n, (out_valid && !out_ready) |-> !in_ready, "request taken while response stalled")
  `ASSERT_PROP(a_stop_no_data, clk, rst_n, (in_fire && in_data.operation == OP_STOP) |=> !out_data.data_valid, "stop produced a data byte")

endmodule

/* bench/i2c_target_register_file_tb.sv */
// ----------------------------------------------------------------------------
// i2c_target_register_file_tb
// directed and random bus events and local accesses under backpressure, checked against
// an in-bench model of the byte store, pointer and bus phase
// ----------------------------------------------------------------------------
module i2c_target_register_file_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2crf_pkg::*;

  localparam int MAP_BYTES    = 128;
  localparam int CLK_HALF     = 5;
  localparam int EVENT_COUNT  = 1400;
  localparam int TAIL_CYCLES  = 20;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct {
    in_req_t req;
    bit      drain;
  } bus_event_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_rsp_t out_data;

  bus_event_t event_q[$];
  out_rsp_t   rsp_expect_q[$];

  logic [7:0] map_bytes [256];
  logic [7:0] map_ptr;
  logic [2:0] map_phase;

  int error_count = 0;
  int cycle_count = 0;
  int req_taken = 0;
  int split_a = 0;
  int split_b = 0;
  int send_idle_pct;
  int recv_idle_pct;

  assign send_idle_pct = (req_taken < split_a) ? 21 : (req_taken < split_b) ? 79 : 0;
  assign recv_idle_pct = (req_taken < split_a) ? 79 : (req_taken < split_b) ? 21 : 0;

  i2c_target_register_file #(
    .REG_BYTES(MAP_BYTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic logic [7:0] take_tx_byte();
    logic [7:0] b;
    b = BYTE_EMPTY;
    if (map_ptr < MAP_BYTES) begin
      b = map_bytes[map_ptr];
      map_ptr = map_ptr + 8'd1;
    end
    return b;
  endfunction

  function automatic out_rsp_t predict_response(in_req_t r);
    out_rsp_t   rsp;
    logic [7:0] cmd;
    rsp = '0;
    case (r.operation)
      OP_WR_ADDR: begin
        map_phase = PH_PTR;
      end
      OP_BYTE_RX: begin
        if (map_phase == PH_PTR) begin
          map_ptr = r.data_in;
          map_phase = PH_RX;
        end else if (map_phase == PH_RX && map_ptr < MAP_BYTES) begin
          map_bytes[map_ptr] = r.data_in;
          map_ptr = map_ptr + 8'd1;
        end
      end
      OP_RD_ADDR: begin
        map_phase = PH_TX;
        rsp.data_out = take_tx_byte();
        rsp.data_valid = 1'b1;
      end
      OP_BYTE_TX: begin
        rsp.data_out = take_tx_byte();
        rsp.data_valid = 1'b1;
      end
      OP_STOP: begin
        if (map_phase == PH_RX) begin
          cmd = map_bytes[0];
          rsp.write_done = 1'b1;
          if (cmd == CMD_RESET) begin
            rsp.reset_request = 1'b1;
          end else if (cmd == CMD_RELOAD) begin
            map_bytes[1] = BYTE1_INIT;
          end else if (cmd == CMD_BOOT) begin
            rsp.boot_request = 1'b1;
          end
          map_bytes[0] = 8'h00;
        end else if (map_phase == PH_TX) begin
          rsp.read_done = 1'b1;
        end
        map_phase = PH_IDLE;
      end
      OP_BUS_ERR: begin
        map_phase = PH_IDLE;
      end
      OP_LOCAL_RD: begin
        rsp.data_out = (r.reg_index < MAP_BYTES) ? map_bytes[r.reg_index] : BYTE_EMPTY;
        rsp.data_valid = 1'b1;
      end
      OP_LOCAL_WR: begin
        if (r.reg_index < MAP_BYTES) begin
          map_bytes[r.reg_index] = r.data_in;
        end
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  task automatic queue_event(logic [2:0] op, logic [7:0] din, logic [7:0] idx,
                             bit drain = 1'b0);
    bus_event_t ev;
    ev.req.operation = op;
    ev.req.data_in = din;
    ev.req.reg_index = idx;
    ev.drain = drain;
    event_q.push_back(ev);
  endtask

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    error_count++;
  endtask

  // request driver
  always @(posedge clk) begin
    bus_event_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) begin
        rsp_expect_q.push_back(predict_response(in_data));
        req_taken <= req_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (event_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
            !(event_q[0].drain && rsp_expect_q.size() != 0)) begin
          nxt = event_q.pop_front();
          in_valid <= 1'b1;
          in_data <= nxt.req;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    out_rsp_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (rsp_expect_q.size() == 0) begin
          report_mismatch("response with none expected", out_data.data_out, 8'h00);
        end else begin
          want = rsp_expect_q.pop_front();
          if (out_data.data_out !== want.data_out)
            report_mismatch("data_out", out_data.data_out, want.data_out);
          if (out_data.data_valid !== want.data_valid)
            report_mismatch("data_valid", out_data.data_valid, want.data_valid);
          if (out_data.write_done !== want.write_done)
            report_mismatch("write_done", out_data.write_done, want.write_done);
          if (out_data.read_done !== want.read_done)
            report_mismatch("read_done", out_data.read_done, want.read_done);
          if (out_data.reset_request !== want.reset_request)
            report_mismatch("reset_request", out_data.reset_request, want.reset_request);
          if (out_data.boot_request !== want.boot_request)
            report_mismatch("boot_request", out_data.boot_request, want.boot_request);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout with %0d responses outstanding", rsp_expect_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int         directed;
    int         kind;
    int         sel;
    int         nbytes;
    logic [7:0] ptr;
    logic [7:0] din;

    for (int i = 0; i < 256; i++) begin
      map_bytes[i] = 8'h00;
    end
    map_bytes[1] = BYTE1_INIT;
    map_bytes[2] = BYTE2_INIT;
    map_bytes[3] = BYTE3_INIT;
    map_ptr = 8'h00;
    map_phase = PH_IDLE;

    // reset contents, out-of-range local access, ignored bytes
    queue_event(OP_LOCAL_RD, 8'h00, 8'd1);
    queue_event(OP_LOCAL_RD, 8'h00, 8'hFF);
    queue_event(OP_LOCAL_WR, 8'hFF, 8'(MAP_BYTES - 1));
    queue_event(OP_LOCAL_WR, 8'h55, 8'd200);
    queue_event(OP_BYTE_RX, 8'h12, 8'h00);
    queue_event(OP_STOP, 8'h00, 8'h00);
    queue_event(OP_WR_ADDR, 8'h00, 8'h00);
    queue_event(OP_STOP, 8'h00, 8'h00);
    // write running past the end
    queue_event(OP_WR_ADDR, 8'h00, 8'h00);
    queue_event(OP_BYTE_RX, 8'(MAP_BYTES - 2), 8'h00);
    queue_event(OP_BYTE_RX, 8'h00, 8'h00);
    queue_event(OP_BYTE_RX, 8'hFF, 8'h00);
    queue_event(OP_BYTE_RX, 8'h33, 8'h00);
    queue_event(OP_STOP, 8'h00, 8'h00);
    // command byte handling at stop
    queue_event(OP_LOCAL_WR, CMD_RESET, 8'd0);
    queue_event(OP_WR_ADDR, 8'h00, 8'h00);
    queue_event(OP_BYTE_RX, 8'd5, 8'h00);
    queue_event(OP_STOP, 8'h00, 8'h00);
    queue_event(OP_LOCAL_WR, 8'h00, 8'd1);
    queue_event(OP_LOCAL_WR, CMD_RELOAD, 8'd0);
    queue_event(OP_WR_ADDR, 8'h00, 8'h00);
    queue_event(OP_BYTE_RX, 8'h80, 8'h00);
    queue_event(OP_RD_ADDR, 8'h00, 8'h00);
    queue_event(OP_STOP, 8'h00, 8'h00);
    queue_event(OP_LOCAL_WR, CMD_BOOT, 8'd0);
    queue_event(OP_WR_ADDR, 8'h00, 8'h00);
    queue_event(OP_BYTE_RX, 8'(MAP_BYTES - 2), 8'h00);
    queue_event(OP_BYTE_TX, 8'h00, 8'h00);
    queue_event(OP_BYTE_TX, 8'h00, 8'h00);
    queue_event(OP_STOP, 8'h00, 8'h00);
    queue_event(OP_BUS_ERR, 8'h00, 8'h00);
    directed = event_q.size();

    while (event_q.size() < directed + EVENT_COUNT) begin
      kind = $urandom_range(0, 99);
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        ptr = 8'($urandom_range(0, MAP_BYTES - 1));
      end else if (sel < 70) begin
        ptr = 8'd0;
      end else if (sel < 85) begin
        ptr = 8'($urandom_range(MAP_BYTES - 8, MAP_BYTES - 1));
      end else begin
        ptr = 8'($urandom_range(MAP_BYTES, 255));
      end
      nbytes = $urandom_range(0, 6);
      if (kind < 35) begin
        queue_event(OP_WR_ADDR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    $urandom_range(0, 99) == 0);
        queue_event(OP_BYTE_RX, ptr, 8'($urandom_range(0, 255)));
        for (int k = 0; k < nbytes; k++) begin
          din = 8'($urandom_range(0, 255));
          if (k == 0 && ptr == 8'd0 && $urandom_range(0, 1) == 1)
            din = 8'($urandom_range(CMD_RESET, CMD_BOOT));
          queue_event(OP_BYTE_RX, din, 8'($urandom_range(0, 255)));
        end
        queue_event(($urandom_range(0, 9) != 0) ? OP_STOP : OP_BUS_ERR,
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else if (kind < 65) begin
        if ($urandom_range(0, 9) < 7) begin
          queue_event(OP_WR_ADDR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      $urandom_range(0, 99) == 0);
          queue_event(OP_BYTE_RX, ptr, 8'($urandom_range(0, 255)));
        end
        queue_event(OP_RD_ADDR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        for (int k = 0; k < nbytes; k++) begin
          queue_event(OP_BYTE_TX, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        queue_event(($urandom_range(0, 9) != 0) ? OP_STOP : OP_BUS_ERR,
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else if (kind < 80) begin
        queue_event(($urandom_range(0, 1) != 0) ? OP_LOCAL_RD : OP_LOCAL_WR,
                    8'($urandom_range(0, 255)),
                    8'(($urandom_range(0, 3) != 0) ? $urandom_range(0, MAP_BYTES - 1)
                                                   : $urandom_range(0, 255)));
      end else begin
        queue_event(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
      end
    end

    split_a = event_q.size() / 3;
    split_b = 2 * event_q.size() / 3;
    event_q[directed].drain = 1'b1;
    event_q[split_a].drain = 1'b1;
    event_q[split_b].drain = 1'b1;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (event_q.size() != 0 || in_valid || rsp_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (rsp_expect_q.size() != 0) begin
      report_mismatch("responses never returned", 8'(rsp_expect_q.size()), 8'h00);
    end

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* i2c_target_register_file.f */
+incdir+rtl
rtl/i2crf_pkg.sv
rtl/i2crf_mem.sv
rtl/i2crf_ctrl.sv
rtl/i2c_target_register_file.sv
bench/i2c_target_register_file_tb.sv
